// ===== rtl/core/fet_pkg.sv =====
// Shared constants, types and the severity lookup for the fault event table.
`default_nettype none

package fet_pkg;

  // Table geometry
  localparam int SLOTS   = 32;
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int CODE_W  = 16;
  localparam int SEV_W   = 2;
  localparam int COUNT_W = 32;
  localparam int LEVELS  = 3;
  localparam int ACT_W   = 6;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Operation codes
  typedef enum logic [1:0] {
    FUNC_RAISE     = 2'd0,
    FUNC_CLEAR     = 2'd1,
    FUNC_CLEAR_ALL = 2'd2,
    FUNC_QUERY     = 2'd3
  } func_e;

  // One stored table entry
  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [SEV_W-1:0]   sev;
    logic [COUNT_W-1:0] cnt;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Outcome of one pass over the table
  typedef struct packed {
    logic               done;
    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic [SEV_W-1:0]   hit_sev;
    logic [COUNT_W-1:0] hit_cnt;
    logic               free;
    logic [IDX_W-1:0]   free_idx;
  } scan_res_t;

  // Map the category in bits 11..8 of a code to a default severity
  function automatic logic [SEV_W-1:0] sev_of_code(input logic [CODE_W-1:0] code);
    logic [SEV_W-1:0] sev;
    case (code[11:8]) inside
      4'h2, 4'h5, 4'h7, 4'h8: sev = 2'd2;
      4'h3, 4'hA:             sev = 2'd3;
      default:                sev = 2'd1;
    endcase
    return sev;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fet_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/core/fet_scan.sv =====
// Slot scanner: one compare per cycle for the matching code and the first free slot.
`default_nettype none

module fet_scan import fet_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [CODE_W-1:0] code_i,
  input  logic [SLOTS-1:0]  active_i,
  input  entry_t            rdata_i,
  output logic [IDX_W-1:0]  raddr_o,
  output scan_res_t         res_o
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  logic               run_q, run_d;
  logic               pend_q, pend_d;
  logic               done_q, done_d;
  logic               hit_q, hit_d;
  logic               free_q, free_d;
  logic [IDX_W-1:0]   iss_q, iss_d;
  logic [IDX_W-1:0]   pidx_q, pidx_d;
  logic [IDX_W-1:0]   hit_idx_q, hit_idx_d;
  logic [IDX_W-1:0]   free_idx_q, free_idx_d;
  logic [SEV_W-1:0]   hit_sev_q, hit_sev_d;
  logic [COUNT_W-1:0] hit_cnt_q, hit_cnt_d;
  logic               slot_act;
  logic               is_hit;
  logic               is_free;

  // Compare the entry read in the previous cycle
  assign slot_act = active_i[pidx_q];
  assign is_hit   = pend_q && slot_act && (rdata_i.code == code_i);
  assign is_free  = pend_q && !slot_act && !free_q;
  assign raddr_o  = iss_q;

  // Advance the read address and collect the outcome
  always_comb begin
    run_d      = run_q;
    pend_d     = pend_q;
    done_d     = 1'b0;
    hit_d      = hit_q;
    free_d     = free_q;
    iss_d      = iss_q;
    pidx_d     = pidx_q;
    hit_idx_d  = hit_idx_q;
    free_idx_d = free_idx_q;
    hit_sev_d  = hit_sev_q;
    hit_cnt_d  = hit_cnt_q;
    if (start_i) begin
      run_d  = 1'b1;
      pend_d = 1'b0;
      hit_d  = 1'b0;
      free_d = 1'b0;
      iss_d  = '0;
    end else begin
      if (run_q) begin
        pend_d = 1'b1;
        pidx_d = iss_q;
        if (iss_q == LAST_IDX) begin
          run_d = 1'b0;
        end else begin
          iss_d = iss_q + IDX_W'(1);
        end
      end else begin
        pend_d = 1'b0;
      end
      if (is_hit) begin
        hit_d     = 1'b1;
        hit_idx_d = pidx_q;
        hit_sev_d = rdata_i.sev;
        hit_cnt_d = rdata_i.cnt;
        run_d     = 1'b0;
        pend_d    = 1'b0;
        done_d    = 1'b1;
      end else if (pend_q) begin
        if (is_free) begin
          free_d     = 1'b1;
          free_idx_d = pidx_q;
        end
        if (pidx_q == LAST_IDX) begin
          done_d = 1'b1;
        end
      end
    end
  end

  // Hold control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      pend_q <= 1'b0;
      done_q <= 1'b0;
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      pend_q <= pend_d;
      done_q <= done_d;
      hit_q  <= hit_d;
      free_q <= free_d;
    end
  end

  // Hold indexes and captured entry fields
  always_ff @(posedge clk_i) begin
    iss_q      <= iss_d;
    pidx_q     <= pidx_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    hit_sev_q  <= hit_sev_d;
    hit_cnt_q  <= hit_cnt_d;
  end

  assign res_o.done     = done_q;
  assign res_o.hit      = hit_q;
  assign res_o.hit_idx  = hit_idx_q;
  assign res_o.hit_sev  = hit_sev_q;
  assign res_o.hit_cnt  = hit_cnt_q;
  assign res_o.free     = free_q;
  assign res_o.free_idx = free_idx_q;

endmodule

`default_nettype wire

// ===== rtl/core/fault_event_table.sv =====
// Fault event table: sequencer, entry RAM, slot flags and table-wide status.
// Operation: raise, clear and query scan all slots, one per cycle through the
//   shared comparator in fet_scan, from start to done_o, and stop early when
//   the code is found. Clear-all completes without a scan.
// Throughput: busy holds off a new item until the last scan has reported; clear-all every cycle.
// Reset: all slots free, counts and total zero; the result cannot be stalled.
`default_nettype none

module fault_event_table import fet_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func_i,
  input  logic [CODE_W-1:0]  code_i,
  input  logic [SEV_W-1:0]   forced_level_i,
  output logic               done_o,
  output logic               accepted_o,
  output logic [COUNT_W-1:0] entry_count_o,
  output logic [SEV_W-1:0]   entry_severity_o,
  output logic [SEV_W-1:0]   system_severity_o,
  output logic [ACT_W-1:0]   active_entries_o,
  output logic [COUNT_W-1:0] total_raised_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;
  localparam int   EXT_W   = CNT_W + ACT_W;

  logic               state_q, state_d;
  logic               done_q, done_d;
  logic [SLOTS-1:0]   active_q, active_d;
  logic [CNT_W-1:0]   sev_cnt_q [LEVELS];
  logic [CNT_W-1:0]   sev_cnt_d [LEVELS];
  logic [COUNT_W-1:0] total_q, total_d;
  logic [1:0]         func_q;
  logic [CODE_W-1:0]  code_q;
  logic [SEV_W-1:0]   forced_q;
  logic               acc_q, acc_d;
  logic [COUNT_W-1:0] ecnt_q, ecnt_d;
  logic [SEV_W-1:0]   esev_q, esev_d;
  logic               accept;
  logic               scan_start;
  scan_res_t          scan_res;
  logic [IDX_W-1:0]   raddr;
  entry_t             rdata;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  entry_t             wdata;
  logic               inc_en, dec_en;
  logic [SEV_W-1:0]   inc_sev, dec_sev;
  logic [SEV_W-1:0]   new_sev;
  logic [COUNT_W-1:0] hit_next;
  logic [COUNT_W-1:0] total_next;
  logic [CNT_W-1:0]   act_sum;
  logic [EXT_W-1:0]   act_ext;

  assign busy       = (state_q != ST_IDLE);
  assign accept     = start && !busy;
  assign scan_start = accept && (func_i != FUNC_CLEAR_ALL);

  // Entry storage: code, severity and count per slot
  fet_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  fet_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (scan_start),
    .code_i   (code_q),
    .active_i (active_q),
    .rdata_i  (rdata),
    .raddr_o  (raddr),
    .res_o    (scan_res)
  );

  // Saturating increments and the severity of a newly allocated entry
  assign hit_next   = (scan_res.hit_cnt == COUNT_MAX) ? scan_res.hit_cnt
                                                      : scan_res.hit_cnt + COUNT_W'(1);
  assign total_next = (total_q == COUNT_MAX) ? total_q : total_q + COUNT_W'(1);
  assign new_sev    = (forced_q != '0) ? forced_q : sev_of_code(code_q);

  // Apply clear-all at once and the other operations once the scan reports
  always_comb begin
    state_d  = state_q;
    done_d   = 1'b0;
    active_d = active_q;
    total_d  = total_q;
    acc_d    = acc_q;
    ecnt_d   = ecnt_q;
    esev_d   = esev_q;
    we       = 1'b0;
    waddr    = scan_res.hit_idx;
    wdata    = '{code: code_q, sev: scan_res.hit_sev, cnt: hit_next};
    inc_en   = 1'b0;
    inc_sev  = new_sev;
    dec_en   = 1'b0;
    dec_sev  = scan_res.hit_sev;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (func_i == FUNC_CLEAR_ALL) begin
            active_d = '0;
            total_d  = '0;
            acc_d    = 1'b1;
            ecnt_d   = '0;
            esev_d   = '0;
            done_d   = 1'b1;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_res.done) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
          acc_d   = 1'b0;
          ecnt_d  = '0;
          esev_d  = '0;
          case (func_q)
            FUNC_RAISE: begin
              if (scan_res.hit) begin
                we      = 1'b1;
                acc_d   = 1'b1;
                ecnt_d  = hit_next;
                esev_d  = scan_res.hit_sev;
                total_d = total_next;
              end else if (scan_res.free) begin
                we       = 1'b1;
                waddr    = scan_res.free_idx;
                wdata    = '{code: code_q, sev: new_sev, cnt: COUNT_W'(1)};
                active_d[scan_res.free_idx] = 1'b1;
                inc_en   = 1'b1;
                acc_d    = 1'b1;
                ecnt_d   = COUNT_W'(1);
                esev_d   = new_sev;
                total_d  = total_next;
              end
            end
            FUNC_CLEAR: begin
              if (scan_res.hit) begin
                active_d[scan_res.hit_idx] = 1'b0;
                dec_en = 1'b1;
                acc_d  = 1'b1;
              end
            end
            default: begin
              if (scan_res.hit) begin
                acc_d  = 1'b1;
                ecnt_d = scan_res.hit_cnt;
                esev_d = scan_res.hit_sev;
              end
            end
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Track the number of active slots at each severity level
  always_comb begin
    for (int k = 0; k < LEVELS; k++) begin
      sev_cnt_d[k] = sev_cnt_q[k];
      if (accept && (func_i == FUNC_CLEAR_ALL)) begin
        sev_cnt_d[k] = '0;
      end else begin
        if (inc_en && (inc_sev == SEV_W'(k + 1))) begin
          sev_cnt_d[k] = sev_cnt_q[k] + CNT_W'(1);
        end
        if (dec_en && (dec_sev == SEV_W'(k + 1))) begin
          sev_cnt_d[k] = sev_cnt_q[k] - CNT_W'(1);
        end
      end
    end
  end

  // Hold control state and table status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      done_q    <= 1'b0;
      active_q  <= '0;
      total_q   <= '0;
      for (int k = 0; k < LEVELS; k++) begin
        sev_cnt_q[k] <= '0;
      end
    end else begin
      state_q   <= state_d;
      done_q    <= done_d;
      active_q  <= active_d;
      total_q   <= total_d;
      for (int k = 0; k < LEVELS; k++) begin
        sev_cnt_q[k] <= sev_cnt_d[k];
      end
    end
  end

  // Capture the item and the result fields
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q   <= func_i;
      code_q   <= code_i;
      forced_q <= forced_level_i;
    end
    acc_q  <= acc_d;
    ecnt_q <= ecnt_d;
    esev_q <= esev_d;
  end

  // Derive table-wide status from the level counters
  assign act_sum = sev_cnt_q[0] + sev_cnt_q[1] + sev_cnt_q[2];
  assign act_ext = EXT_W'(act_sum);

  assign done_o            = done_q;
  assign accepted_o        = acc_q;
  assign entry_count_o     = ecnt_q;
  assign entry_severity_o  = esev_q;
  assign system_severity_o = (sev_cnt_q[2] != '0) ? 2'd3 :
                             (sev_cnt_q[1] != '0) ? 2'd2 :
                             (sev_cnt_q[0] != '0) ? 2'd1 : 2'd0;
  assign active_entries_o  = act_ext[ACT_W-1:0];
  assign total_raised_o    = total_q;

  // Level counters agree with the slot flags
  a_act_sum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_sum == CNT_W'($countones(active_q)))
    else $error("severity level counters disagree with active slots");

  // The scanner reports only while a scan is running
  a_scan_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_res.done |-> (state_q == ST_SCAN))
    else $error("scan finished outside the scan state");

  // A result appears only once the block is ready again
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == ST_IDLE))
    else $error("result strobe while busy");

  // A refused item carries an empty entry
  a_refused_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !acc_q) |-> ((ecnt_q == '0) && (esev_q == '0)))
    else $error("refused item reports entry data");

endmodule

`default_nettype wire

// ===== tb/sv/fet_result_check.sv =====
// Result predictor and comparator for the fault event table testbench.
`timescale 1ns / 100ps

module fet_result_check import fet_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         func_i,
  input  logic [CODE_W-1:0]  code_i,
  input  logic [SEV_W-1:0]   forced_level_i,
  input  logic               done_i,
  input  logic               accepted_i,
  input  logic [COUNT_W-1:0] entry_count_i,
  input  logic [SEV_W-1:0]   entry_severity_i,
  input  logic [SEV_W-1:0]   system_severity_i,
  input  logic [ACT_W-1:0]   active_entries_i,
  input  logic [COUNT_W-1:0] total_raised_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 refused_o
);

  // Default severity per category, two bits per category, category 0 lowest
  localparam logic [31:0] CAT_LEVEL = 32'h5576_99E5;

  typedef struct packed {
    logic               accepted;
    logic [COUNT_W-1:0] count;
    logic [SEV_W-1:0]   entry_sev;
    logic [SEV_W-1:0]   sys_sev;
    logic [ACT_W-1:0]   active;
    logic [COUNT_W-1:0] total;
  } table_status_t;

  typedef struct {
    func_e             op;
    logic [CODE_W-1:0] code;
    table_status_t     status;
  } fault_outcome_t;

  // Shadow copy of the table
  logic               live_q  [SLOTS];
  logic [CODE_W-1:0]  code_q  [SLOTS];
  logic [SEV_W-1:0]   sev_q   [SLOTS];
  logic [COUNT_W-1:0] cnt_q   [SLOTS];
  logic [COUNT_W-1:0] raised_q;

  fault_outcome_t outstanding_outcomes[$];
  fault_outcome_t oldest;
  fault_outcome_t fresh;
  int fail_count;
  int pending;
  int checked;
  int refused;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;
  assign checked_o    = checked;
  assign refused_o    = refused;

  // Apply one operation to the shadow table and return the status it reports
  function automatic table_status_t apply_fault_op(input func_e op,
                                                   input logic [CODE_W-1:0] code,
                                                   input logic [SEV_W-1:0] level);
    table_status_t res;
    int hit;
    int vacant;
    int i;
    res    = '0;
    hit    = -1;
    vacant = -1;
    for (i = 0; i < SLOTS; i++) begin
      if (hit < 0 && live_q[i] && code_q[i] == code) hit = i;
      if (vacant < 0 && !live_q[i]) vacant = i;
    end
    case (op)
      FUNC_RAISE: begin
        // Allocate the lowest free slot for a new code
        if (hit < 0 && vacant >= 0) begin
          hit         = vacant;
          live_q[hit] = 1'b1;
          code_q[hit] = code;
          sev_q[hit]  = (level != '0) ? level : CAT_LEVEL[2 * code[11:8] +: 2];
        end
        if (hit >= 0) begin
          if (cnt_q[hit] != COUNT_MAX) cnt_q[hit] = cnt_q[hit] + COUNT_W'(1);
          if (raised_q != COUNT_MAX) raised_q = raised_q + COUNT_W'(1);
          res.accepted  = 1'b1;
          res.count     = cnt_q[hit];
          res.entry_sev = sev_q[hit];
        end
      end
      FUNC_CLEAR: begin
        if (hit >= 0) begin
          live_q[hit]  = 1'b0;
          cnt_q[hit]   = '0;
          res.accepted = 1'b1;
        end
      end
      FUNC_CLEAR_ALL: begin
        for (i = 0; i < SLOTS; i++) begin
          live_q[i] = 1'b0;
          cnt_q[i]  = '0;
        end
        raised_q     = '0;
        res.accepted = 1'b1;
      end
      default: begin
        if (hit >= 0) begin
          res.accepted  = 1'b1;
          res.count     = cnt_q[hit];
          res.entry_sev = sev_q[hit];
        end
      end
    endcase
    // Gather table-wide status after the operation
    for (i = 0; i < SLOTS; i++) begin
      if (live_q[i]) begin
        res.active = res.active + ACT_W'(1);
        if (sev_q[i] > res.sys_sev) res.sys_sev = sev_q[i];
      end
    end
    res.total = raised_q;
    return res;
  endfunction

  task automatic check_field(input string tag, input string field,
                             input logic [COUNT_W-1:0] want,
                             input logic [COUNT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s: %s expected 0x%0h, got 0x%0h", $time, tag, field, want, got);
      fail_count++;
    end
  endtask

  // Retire results against the oldest prediction, then predict newly taken items
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        live_q[i] = 1'b0;
        code_q[i] = '0;
        sev_q[i]  = '0;
        cnt_q[i]  = '0;
      end
      raised_q = '0;
      outstanding_outcomes.delete();
      pending = 0;
    end else begin
      if (done_i) begin
        if (outstanding_outcomes.size() == 0) begin
          $display("%0t: expected no result, got accepted=%0b count=0x%0h total=0x%0h",
                   $time, accepted_i, entry_count_i, total_raised_i);
          fail_count++;
        end else begin
          string tag;
          oldest = outstanding_outcomes.pop_front();
          tag    = $sformatf("%s 0x%04h", oldest.op.name(), oldest.code);
          check_field(tag, "accepted", COUNT_W'(oldest.status.accepted),
                      COUNT_W'(accepted_i));
          check_field(tag, "entry_count", oldest.status.count, entry_count_i);
          check_field(tag, "entry_severity", COUNT_W'(oldest.status.entry_sev),
                      COUNT_W'(entry_severity_i));
          check_field(tag, "system_severity", COUNT_W'(oldest.status.sys_sev),
                      COUNT_W'(system_severity_i));
          check_field(tag, "active_entries", COUNT_W'(oldest.status.active),
                      COUNT_W'(active_entries_i));
          check_field(tag, "total_raised", oldest.status.total, total_raised_i);
          checked++;
        end
      end
      if (start && !busy) begin
        fresh.op     = func_e'(func_i);
        fresh.code   = code_i;
        fresh.status = apply_fault_op(fresh.op, code_i, forced_level_i);
        if (fresh.op == FUNC_RAISE && !fresh.status.accepted) refused++;
        outstanding_outcomes.push_back(fresh);
      end
      pending = outstanding_outcomes.size();
    end
  end

endmodule

// ===== tb/sv/fault_event_table_tb.sv =====
// Stimulus, clock, reset and verdict for the fault event table testbench.
`timescale 1ns / 100ps

module fault_event_table_tb import fet_pkg::*;;

  localparam int CYCLE_LIMIT = 400000;
  localparam int POOL_MAX    = 48;
  localparam int DRAIN_WAIT  = 2 * SLOTS + 8;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               start          = 1'b0;
  logic [1:0]         func_i         = FUNC_QUERY;
  logic [CODE_W-1:0]  code_i         = '0;
  logic [SEV_W-1:0]   forced_level_i = '0;
  logic               busy;
  logic               done_o;
  logic               accepted_o;
  logic [COUNT_W-1:0] entry_count_o;
  logic [SEV_W-1:0]   entry_severity_o;
  logic [SEV_W-1:0]   system_severity_o;
  logic [ACT_W-1:0]   active_entries_o;
  logic [COUNT_W-1:0] total_raised_o;

  int fail_count;
  int pending;
  int checked;
  int refused;
  int cycles = 0;
  int sent_by_op [4];
  bit idle_on;
  logic [CODE_W-1:0] code_pool [POOL_MAX];

  always #4 clk_i = ~clk_i;

  fault_event_table DUT (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .func_i,
    .code_i,
    .forced_level_i,
    .done_o,
    .accepted_o,
    .entry_count_o,
    .entry_severity_o,
    .system_severity_o,
    .active_entries_o,
    .total_raised_o
  );

  fet_result_check u_check (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .func_i,
    .code_i,
    .forced_level_i,
    .done_i            (done_o),
    .accepted_i        (accepted_o),
    .entry_count_i     (entry_count_o),
    .entry_severity_i  (entry_severity_o),
    .system_severity_i (system_severity_o),
    .active_entries_i  (active_entries_o),
    .total_raised_i    (total_raised_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .checked_o         (checked),
    .refused_o         (refused)
  );

  // Stop a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("** fault_event_table: FAILED **");
      $finish;
    end
  end

  // Present one item and hold it until the block takes it
  task automatic send_item(input func_e op, input logic [CODE_W-1:0] code,
                           input logic [SEV_W-1:0] level);
    start          <= 1'b1;
    func_i         <= op;
    code_i         <= code;
    forced_level_i <= level;
    do @(posedge clk_i); while (busy);
    sent_by_op[int'(op)]++;
  endtask

  task automatic pause_sender(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic maybe_idle();
    if (idle_on && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 14));
  endtask

  // Hold off until every outstanding item has produced its result
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Walk every category, forced levels, repeat raise, clear and query edge cases
  task automatic run_directed();
    int c;
    send_item(FUNC_QUERY, 16'h0000, 2'd0);
    send_item(FUNC_CLEAR, 16'hFFFF, 2'd3);
    for (c = 0; c < 16; c++) begin
      send_item(FUNC_RAISE, {4{4'(c)}}, 2'd0);
    end
    send_item(FUNC_RAISE, 16'h1234, 2'd3);
    send_item(FUNC_RAISE, 16'h3A00, 2'd1);
    send_item(FUNC_RAISE, 16'hA5A5, 2'd2);
    // Existing code keeps its stored severity
    send_item(FUNC_RAISE, 16'h3A00, 2'd3);
    send_item(FUNC_QUERY, 16'h3A00, 2'd0);
    send_item(FUNC_CLEAR, 16'h3A00, 2'd0);
    send_item(FUNC_QUERY, 16'h3A00, 2'd0);
    send_item(FUNC_CLEAR, 16'h3A00, 2'd0);
    send_item(FUNC_CLEAR_ALL, 16'hFFFF, 2'd3);
  endtask

  // Fill every slot, overflow the pool, free one slot and reuse it
  task automatic fill_table();
    logic [CODE_W-1:0] base;
    int i;
    base = 16'($urandom);
    send_item(FUNC_CLEAR_ALL, 16'($urandom), 2'($urandom));
    for (i = 0; i < SLOTS + 2; i++) begin
      maybe_idle();
      send_item(FUNC_RAISE, base ^ 16'(i * 263), 2'($urandom));
    end
    send_item(FUNC_QUERY, base, 2'($urandom));
    send_item(FUNC_QUERY, base ^ 16'((SLOTS + 1) * 263), 2'($urandom));
    send_item(FUNC_RAISE, base ^ 16'(5 * 263), 2'($urandom));
    send_item(FUNC_CLEAR, base ^ 16'(7 * 263), 2'($urandom));
    send_item(FUNC_RAISE, base ^ 16'(SLOTS * 263), 2'($urandom));
    send_item(FUNC_RAISE, base ^ 16'((SLOTS + 1) * 263), 2'($urandom));
  endtask

  // Raises most often on a small code pool, so entries repeat and the pool can run out
  task automatic random_item(input int pool_n);
    int pick;
    func_e op;
    logic [CODE_W-1:0] code;
    pick = $urandom_range(0, 99);
    if (pick < 48) op = FUNC_RAISE;
    else if (pick < 68) op = FUNC_CLEAR;
    else if (pick < 70) op = FUNC_CLEAR_ALL;
    else op = FUNC_QUERY;
    if ($urandom_range(0, 4) == 0) code = 16'($urandom);
    else code = code_pool[$urandom_range(0, pool_n - 1)];
    send_item(op, code, 2'($urandom));
  endtask

  initial begin
    int seg;
    int k;
    int pool_n;
    idle_on = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    drain_results();
    fill_table();

    // Random segments, each with its own code pool and idle setting
    for (seg = 0; seg < 22; seg++) begin
      pool_n = $urandom_range(2, POOL_MAX);
      for (k = 0; k < POOL_MAX; k++) code_pool[k] = 16'($urandom);
      idle_on = ($urandom_range(0, 3) != 0);
      if (seg % 8 == 3) fill_table();
      for (k = 0; k < 50; k++) begin
        maybe_idle();
        random_item(pool_n);
      end
      if ($urandom_range(0, 3) == 0) drain_results();
    end

    // Back-to-back tail
    idle_on = 1'b0;
    pool_n  = 40;
    for (k = 0; k < POOL_MAX; k++) code_pool[k] = 16'($urandom);
    for (k = 0; k < 150; k++) random_item(pool_n);

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Sent %0d raise, %0d clear, %0d clear-all and %0d query items",
             sent_by_op[FUNC_RAISE], sent_by_op[FUNC_CLEAR],
             sent_by_op[FUNC_CLEAR_ALL], sent_by_op[FUNC_QUERY]);
    $display("Compared %0d results; %0d raises hit a full table", checked, refused);
    if (fail_count == 0 && pending == 0) begin
      $display("** fault_event_table: PASSED **");
    end else begin
      $display("** fault_event_table: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/fet_pkg.sv
rtl/core/fet_ram.sv
rtl/core/fet_scan.sv
rtl/core/fault_event_table.sv
tb/sv/fet_result_check.sv
tb/sv/fault_event_table_tb.sv
